### rtl/core/wgm_pkg.sv
// Shared types and constants for the wildcard glob matcher.
`timescale 1ns / 1ps
`default_nettype none

package wgm_pkg;

  // Item kinds carried in tuser
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_TEXT  = 2'd1,
    OP_END   = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Pattern metacharacters
  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] ANY_BYTE  = 8'h3F;

  // Widths of the item position field and of the pattern length register
  localparam int unsigned PosW = 6;
  localparam int unsigned LenW = 7;

  // One input item as held in the input register
  typedef struct packed {
    op_e              op;
    logic [PosW-1:0]  position;
    logic [7:0]       byte_in;
  } item_t;

endpackage

`default_nettype wire

### rtl/core/wgm_step.sv
// Closure and one-byte step of the active position set.
`timescale 1ns / 1ps
`default_nettype none

module wgm_step
  import wgm_pkg::*;
#(
  parameter int PATTERN_MAX = 64
) (
  input  logic [PATTERN_MAX:0]        act_i,
  input  logic [PATTERN_MAX-1:0][7:0] pat_i,
  input  logic [7:0]                  byte_i,
  input  logic [LenW-1:0]             len_i,
  output logic [PATTERN_MAX:0]        next_o,
  output logic                        matched_o
);

  logic [PATTERN_MAX-1:0] len_mask;
  logic [PATTERN_MAX-1:0] star;
  logic [PATTERN_MAX-1:0] hit;
  logic [PATTERN_MAX:0]   end_mask;
  logic [PATTERN_MAX:0]   gen;
  logic [PATTERN_MAX:0]   prop;
  logic [PATTERN_MAX:0]   carry;
  logic [PATTERN_MAX:0]   closed;
  logic [PATTERN_MAX:0]   sum;

  // Per-position decode of the pattern against the length and the text byte
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      len_mask[i] = (i < int'(len_i));
      star[i]     = (pat_i[i] == STAR_BYTE) && len_mask[i];
      hit[i]      = ((pat_i[i] == ANY_BYTE) || (pat_i[i] == byte_i)) && len_mask[i];
      end_mask[i] = (int'(len_i) == i);
    end
    // length above the store depth is clamped to the last position
    end_mask[PATTERN_MAX] = (int'(len_i) >= PATTERN_MAX);
  end

  // Empty-match closure: an active star lights the next position, through
  // runs of stars. Same recurrence as a carry chain, so an adder does it.
  assign prop   = {1'b0, star};
  assign gen    = act_i & prop;
  assign sum    = gen + prop;
  assign carry  = sum ^ gen ^ prop;
  assign closed = act_i | carry;

  // Byte step: stars hold, matching literals and '?' advance, end drops out
  assign next_o = {1'b0, closed[PATTERN_MAX-1:0] & star}
                | {closed[PATTERN_MAX-1:0] & hit & ~star, 1'b0};

  assign matched_o = |(closed & end_mask);

endmodule

`default_nettype wire

### rtl/core/wildcard_glob_matcher_top.sv
// Top level of the wildcard glob matcher: stream ports, pattern store, set.
// Path: an item is held in the input register; an end item's result then
// moves on to the output register once that register has room.
// Throughput: one item per cycle; only an end item waits, while the output
// register still holds an untaken result.
// Reset (asynchronous, active low): empties both registers, sets the active
// set to position zero and the length to zero; the pattern store is not reset.
`timescale 1ns / 1ps
`default_nettype none

module wildcard_glob_matcher_top
  import wgm_pkg::*;
#(
  parameter int PATTERN_MAX = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // input stream
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [15:0]     s_axis_tdata,  // [5:0] position, [13:6] byte_in, [15:14] zero
  input  logic [1:0]      s_axis_tuser,  // [1:0] op
  // result stream
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [7:0]      m_axis_tdata,  // [0] matched, [7:1] zero
  // pattern length register
  input  logic            cfg_we_i,
  input  logic [LenW-1:0] cfg_wdata_i
);

  localparam logic [PATTERN_MAX:0] SetInit = {{PATTERN_MAX{1'b0}}, 1'b1};

  item_t                       item_q;
  logic                        in_valid_q;
  logic [PATTERN_MAX-1:0][7:0] pat_q;
  logic [PATTERN_MAX:0]        act_q;
  logic [LenW-1:0]             len_q;
  logic                        out_valid_q;
  logic                        matched_q;
  logic                        out_free;
  logic                        adv;
  logic                        s_xfer;
  logic [PATTERN_MAX:0]        step_next;
  logic                        step_matched;

  // Handshake: only an end item needs room in the output register
  assign out_free      = !out_valid_q || m_axis_tready;
  assign adv           = in_valid_q && ((item_q.op != OP_END) || out_free);
  assign s_axis_tready = !in_valid_q || adv;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      item_q.op       <= op_e'(s_axis_tuser);
      item_q.position <= s_axis_tdata[PosW-1:0];
      item_q.byte_in  <= s_axis_tdata[PosW+7:PosW];
    end
  end

  // Pattern length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (cfg_we_i) begin
      len_q <= cfg_wdata_i;
    end
  end

  // Pattern store; writes beyond the depth are dropped
  always_ff @(posedge clk_i) begin
    if (adv && (item_q.op == OP_WRITE)) begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
        if (int'(item_q.position) == i) begin
          pat_q[i] <= item_q.byte_in;
        end
      end
    end
  end

  wgm_step #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_step (
    .act_i    (act_q),
    .pat_i    (pat_q),
    .byte_i   (item_q.byte_in),
    .len_i    (len_q),
    .next_o   (step_next),
    .matched_o(step_matched)
  );

  // Active set: stepped by text bytes, restarted by an end item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= SetInit;
    end else if (adv) begin
      case (item_q.op)
        OP_TEXT: act_q <= step_next;
        OP_END:  act_q <= SetInit;
        default: act_q <= act_q;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= adv && (item_q.op == OP_END);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && (item_q.op == OP_END)) begin
      matched_q <= step_matched;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, matched_q};

endmodule

`default_nettype wire

### rtl/core/wgm_checker.sv
// Port-level checks for the wildcard glob matcher, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module wgm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed or vanished while stalled");

  // Only bit zero of the result carries data
  a_out_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:1] == 7'd0))
    else $error("result padding bits not zero");

  // Input side never stalls while the result side has room
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input stalled with a free result slot");

  // No result is shown once reset has been seen at an edge
  a_reset_out: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid during reset");

endmodule

bind wildcard_glob_matcher_top wgm_checker u_wgm_checker (.*);

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the wildcard glob matcher: directed cases, then random glob traffic.
`timescale 1ns / 1ps

module tb_top;
  import wgm_pkg::*;

  localparam int PMAX         = 64;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 570;
  localparam int SETTLE       = 4;   // cycles for a result-free item to clear the pipeline
  localparam int MAX_REPORTS  = 10;

  typedef logic [7:0] byte_q_t[$];

  // DUT connections; the inputs are driven from time zero
  logic            clk_i         = 1'b0;
  logic            rst_ni        = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [15:0]     s_axis_tdata  = '0;  // [5:0] position, [13:6] byte_in, [15:14] zero
  logic [1:0]      s_axis_tuser  = '0;  // [1:0] op
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [7:0]      m_axis_tdata;        // [0] matched, [7:1] zero
  logic            cfg_we_i      = 1'b0;
  logic [LenW-1:0] cfg_wdata_i   = '0;

  // Predicted matcher state
  logic [7:0]      pat_mem [PMAX];
  logic [PMAX:0]   live_set = (PMAX+1)'(1);
  logic [LenW-1:0] glob_len = '0;
  logic [7:0]      verdict_q[$];

  int item_count  = 0;
  int error_count = 0;
  int cycle_count = 0;
  int burst_left  = 0;
  int rx_left     = 0;
  int rx_mode     = 0;
  logic [7:0] want_tdata;

  wildcard_glob_matcher_top #(
    .PATTERN_MAX(PMAX)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Run guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("wildcard_glob_matcher_top: mismatch");
      $finish;
    end
  end

  // Receiver back-pressure: runs of always-ready, random and fully stalled
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(1, 20);
    end
    rx_left--;
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= 1'b0;
    endcase
  end

  task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("t=%0t %s: expected tdata %02h, got %02h", $time, what, want, got);
  endtask

  // Compare each result transfer with the oldest predicted verdict
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("unexpected result", 8'h00, m_axis_tdata);
      end else begin
        want_tdata = verdict_q.pop_front();
        if (m_axis_tdata !== want_tdata)
          report_mismatch("wrong verdict", want_tdata, m_axis_tdata);
      end
    end
  end

  function automatic int eff_len();
    return (glob_len > PMAX) ? PMAX : int'(glob_len);
  endfunction

  // A live star position also enables the one after it (empty run)
  function automatic logic [PMAX:0] star_closure(logic [PMAX:0] s);
    int n;
    n = eff_len();
    for (int i = 0; i < PMAX; i++)
      if (i < n && s[i] && pat_mem[i] == STAR_BYTE) s[i+1] = 1'b1;
    return s;
  endfunction

  // Advance the predicted matcher by one accepted item
  task automatic glob_apply(op_e op, logic [5:0] pos, logic [7:0] data);
    logic [PMAX:0] cur;
    logic [PMAX:0] nxt;
    int n;
    n = eff_len();
    case (op)
      OP_WRITE: pat_mem[pos] = data;
      OP_TEXT: begin
        cur = star_closure(live_set);
        nxt = '0;
        for (int i = 0; i < n; i++) begin
          if (cur[i]) begin
            if (pat_mem[i] == STAR_BYTE) nxt[i] = 1'b1;
            else if (pat_mem[i] == ANY_BYTE || pat_mem[i] == data) nxt[i+1] = 1'b1;
          end
        end
        live_set = nxt;
      end
      OP_END: begin
        cur = star_closure(live_set);
        verdict_q.push_back({7'd0, cur[n]});
        live_set = (PMAX+1)'(1);
      end
      default: ;
    endcase
  endtask

  // One input transfer; leaves tvalid high so bursts run back to back
  task automatic send_item(op_e op, logic [5:0] pos, logic [7:0] data);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, data, pos};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    glob_apply(op, pos, data);
    item_count++;
    @(negedge clk_i);
  endtask

  // Length register is only written with the block idle
  task automatic set_length(logic [LenW-1:0] len);
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    glob_len = len;
  endtask

  function automatic byte_q_t str_bytes(string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  task automatic send_text(byte_q_t txt);
    foreach (txt[i]) send_item(OP_TEXT, 6'($urandom_range(0, 63)), txt[i]);
  endtask

  task automatic end_text();
    send_item(OP_END, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
  endtask

  task automatic load_pattern(byte_q_t pat);
    foreach (pat[i]) send_item(OP_WRITE, 6'(i), pat[i]);
    set_length(LenW'(pat.size()));
  endtask

  task automatic check_text(string s);
    send_text(str_bytes(s));
    end_text();
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_empty_pattern();
    set_length(7'd0);
    end_text();
    check_text("a");
  endtask

  // Whole store as stars; lengths at and above the store size
  task automatic test_full_store_and_cap();
    for (int i = 0; i < PMAX; i++) send_item(OP_WRITE, 6'(i), STAR_BYTE);
    set_length(7'd127);
    end_text();
    set_length(7'd64);
    check_text("xyz");
  endtask

  task automatic test_case_kept();
    load_pattern(str_bytes("aB"));
    check_text("aB");
    check_text("ab");
    check_text("aBc");
  endtask

  // Byte zero and byte 0xFF are plain literals
  task automatic test_extreme_bytes();
    byte_q_t pat;
    byte_q_t txt;
    pat = {8'h00, ANY_BYTE, 8'hFF};
    load_pattern(pat);
    txt = {8'h00, 8'h5A, 8'hFF};
    send_text(txt);
    end_text();
    txt = {8'h00, 8'hFF};
    send_text(txt);
    end_text();
  endtask

  // A question mark needs a byte; it cannot run past the end of the text
  task automatic test_question();
    load_pattern(str_bytes("?"));
    end_text();
    check_text("x");
  endtask

  task automatic test_star();
    load_pattern(str_bytes("a**b"));
    check_text("ab");
    check_text("axyzb");
    check_text("a");
    load_pattern(str_bytes("*"));
    end_text();
  endtask

  task automatic test_unused_op();
    send_item(OP_NONE, 6'h3F, 8'hFF);
    send_item(OP_NONE, 6'h00, 8'h00);
    end_text();
  endtask

  // Length and pattern altered part way through a text
  task automatic test_mid_text_change();
    load_pattern(str_bytes("ab"));
    send_text(str_bytes("a"));
    set_length(7'd1);
    end_text();
    load_pattern(str_bytes("ab"));
    send_text(str_bytes("a"));
    send_item(OP_WRITE, 6'd1, 8'h63);
    send_text(str_bytes("c"));
    end_text();
  endtask

  function automatic logic [7:0] pick_text_byte();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 3) return 8'h61;
    if (roll == 3) return 8'h62;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic byte_q_t random_glob(int n);
    byte_q_t q;
    int roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 9);
      if (roll < 3) q.push_back(8'h61);
      else if (roll == 3) q.push_back(8'h62);
      else if (roll < 6) q.push_back(STAR_BYTE);
      else if (roll == 6) q.push_back(ANY_BYTE);
      else q.push_back(8'($urandom_range(0, 255)));
    end
    return q;
  endfunction

  // Text built to fit the glob: stars expand to short random runs
  function automatic byte_q_t fitting_text(byte_q_t pat);
    byte_q_t q;
    int run;
    foreach (pat[i]) begin
      if (pat[i] == STAR_BYTE) begin
        run = $urandom_range(0, 3);
        repeat (run) q.push_back(pick_text_byte());
      end else if (pat[i] == ANY_BYTE) begin
        q.push_back(8'($urandom_range(0, 255)));
      end else begin
        q.push_back(pat[i]);
      end
    end
    return q;
  endfunction

  // Load a random glob, set the length, then run a few texts against it
  task automatic run_glob_case();
    byte_q_t pat;
    byte_q_t txt;
    int roll;
    int n;
    int texts;
    int len;
    roll = $urandom_range(0, 19);
    n = (roll < 17) ? $urandom_range(0, 10) : (roll < 19) ? $urandom_range(11, 40) : PMAX;
    pat = random_glob(n);
    foreach (pat[i]) send_item(OP_WRITE, 6'(i), pat[i]);
    len = (n == PMAX && $urandom_range(0, 1) == 1) ? $urandom_range(PMAX + 1, 127) : n;
    set_length(LenW'(len));
    texts = $urandom_range(1, 3);
    repeat (texts) begin
      if ($urandom_range(0, 9) < 7) begin
        txt = fitting_text(pat);
      end else begin
        txt = {};
        repeat ($urandom_range(0, n + 3)) txt.push_back(pick_text_byte());
      end
      if (txt.size() > 0 && $urandom_range(0, 4) == 0)
        txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
      send_text(txt);
      end_text();
    end
  endtask

  // Short run of arbitrary items, any op
  task automatic inject_noise();
    repeat ($urandom_range(1, 6))
      send_item(op_e'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                8'($urandom_range(0, 255)));
  endtask

  task automatic test_random_traffic();
    int start;
    start = item_count;
    while (item_count - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) != 0) run_glob_case();
      else inject_noise();
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_pattern();
    test_full_store_and_cap();
    test_case_kept();
    test_extreme_bytes();
    test_question();
    test_star();
    test_unused_op();
    test_mid_text_change();
    test_random_traffic();

    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (error_count == 0) begin
      $display("wildcard_glob_matcher_top: match");
    end else begin
      $display("wildcard_glob_matcher_top: mismatch");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/wgm_pkg.sv
rtl/core/wgm_step.sv
rtl/core/wildcard_glob_matcher_top.sv
rtl/core/wgm_checker.sv
tb/tb_top.sv
